@@ src/mmc_pkg.sv @@
// Package with shared constants and types of the matrix multiply chain.
package mmc_pkg;

	localparam int unsigned MAX_DIM_DEF = 8;
	localparam int unsigned ELEM_W = 16;
	localparam int unsigned DIM_W = 4;
	localparam int unsigned VAL_W = 35;
	localparam int unsigned PROD_W = 32;

	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_LOAD_D = 2'd2;
	localparam logic [1:0] OP_COMPUTE = 2'd3;

	localparam logic [2:0] REG_ROWS_A = 3'd0;
	localparam logic [2:0] REG_INNER_DIM = 3'd1;
	localparam logic [2:0] REG_COLS_B = 3'd2;
	localparam logic [2:0] REG_CHAIN_ENABLE = 3'd3;
	localparam logic [2:0] REG_COLS_D = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0] rows_a;
		logic [DIM_W-1:0] inner_dim;
		logic [DIM_W-1:0] cols_b;
		logic chain_enable;
		logic [DIM_W-1:0] cols_d;
	} cfg_t;

endpackage

@@ src/mmc_mem.sv @@
// Single-port-write, single-port-read synchronous element memory.
module mmc_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [mmc_pkg::ELEM_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [mmc_pkg::ELEM_W-1:0] rdata
);

	logic [mmc_pkg::ELEM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/mmc_mac.sv @@
// Pipelined multiply-accumulate unit with narrowing of the intermediate sum.
module mmc_mac (
	input logic clk,
	input logic arst_n,
	input logic vld_s2,
	input logic first_s2,
	input logic [mmc_pkg::ELEM_W-1:0] opa_s2,
	input logic [mmc_pkg::ELEM_W-1:0] opb_s2,
	output logic [mmc_pkg::VAL_W-1:0] acc_q,
	output logic [mmc_pkg::ELEM_W-1:0] narrow
);

	logic signed [mmc_pkg::PROD_W-1:0] prod_s3;
	logic vld_s3;
	logic first_s3;
	logic signed [mmc_pkg::VAL_W-1:0] acc_base;
	logic signed [mmc_pkg::VAL_W-13:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= $signed(opa_s2) * $signed(opb_s2);
		first_s3 <= first_s2;
		if (vld_s3) begin
			acc_q <= acc_base + mmc_pkg::VAL_W'(prod_s3);
		end
	end

	assign acc_base = first_s3 ? '0 : $signed(acc_q);
	assign shifted = $signed(acc_q[mmc_pkg::VAL_W-1:12]);

	always_comb begin
		if (shifted > 23'sd32767) begin
			narrow = 16'h7fff;
		end else if (shifted < -23'sd32768) begin
			narrow = 16'h8000;
		end else begin
			narrow = shifted[mmc_pkg::ELEM_W-1:0];
		end
	end

endmodule

@@ src/matrix_multiply_chain.sv @@
// Top level of the matrix multiply chain: load, sequencing and result output.
// Usage: load elements of A, B and D with op 0, 1, 2 on the input channel, one
// transfer per cycle while stall is low; a load produces no result. A compute
// transfer (op 3) forms A x B, or M x D when chain_enable is set, with M being
// A x B shifted right by 12 and saturated to 16 bits, and streams every
// result element in row-major order with last on the final one.
// Each element takes inner_dim (or cols_b in the second chain pass) products,
// one operand pair per cycle from the element memories; that memory read port
// sets the rate. The sequencer then waits in its drain state for the sum and
// holds the result element in the output state until it is taken. In chain
// mode a first pass runs before them and computes the rows_a*cols_b elements
// of M, inner_dim products each, into the mid memory without output.
// The input is stalled from the compute transfer until its last result
// transfer. When the output stalls, the sequencer waits with the finished
// element in the output register. Configuration writes are taken at any
// time with ready high, and must be made only while the block is idle.
// Reset clears the control state and sets the dimensions to 8 and
// chain_enable to 0; the element memories are not cleared and each entry
// must be loaded before it is used.
module matrix_multiply_chain #(
	parameter int unsigned MAX_DIM = mmc_pkg::MAX_DIM_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic stall,
	input logic [1:0] op,
	input logic [2:0] row,
	input logic [2:0] col,
	input logic signed [15:0] elem_value,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] out_row,
	output logic [2:0] out_col,
	output logic signed [34:0] out_value,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [3:0] cfg_data
);

	localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned DW = mmc_pkg::DIM_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_DRAIN, ST_OUT
	} state_t;

	state_t state_q;
	mmc_pkg::cfg_t cfg_q;
	logic [DW-1:0] ra, kd, cb, cd, ncols, klim;
	logic pass_q;
	logic [2:0] i_q, j_q, k_q;
	logic [2:0] drain_q;
	logic [2:0] oi_s1, oj_s1, oi_s2, oj_s2;
	logic fin_s1, fin_s2, fin_s3;

	logic in_acc, ld_ok;
	logic [AW-1:0] ld_addr;
	logic we_a, we_b, we_d, we_m;
	logic [AW-1:0] ra_a, ra_b, ra_m;
	logic [mmc_pkg::ELEM_W-1:0] rd_a, rd_b, rd_d, rd_m;
	logic [AW-1:0] wa_m;
	logic vld_s1, first_s1, pass_s1, pass_s2;
	logic [mmc_pkg::ELEM_W-1:0] opa_s2, opb_s2;
	logic [mmc_pkg::VAL_W-1:0] acc_q;
	logic [mmc_pkg::ELEM_W-1:0] narrow;
	logic last_k, last_j, last_i;

	function automatic logic [3:0] eff(input logic [3:0] v);
		if (v == 4'd0) return 4'd1;
		if (v > 4'(MAX_DIM)) return 4'(MAX_DIM);
		return v;
	endfunction

	assign ra = eff(cfg_q.rows_a);
	assign kd = eff(cfg_q.inner_dim);
	assign cb = eff(cfg_q.cols_b);
	assign cd = eff(cfg_q.cols_d);
	assign ncols = (cfg_q.chain_enable && !pass_q) ? cb :
		(cfg_q.chain_enable ? cd : cb);
	assign klim = (pass_q && cfg_q.chain_enable) ? cb : kd;

	assign cfg_ready = 1'b1;
	assign stall = (state_q != ST_IDLE);
	assign in_acc = valid && !stall;
	assign ld_ok = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign ld_addr = AW'(row * 6'(MAX_DIM) + 6'(col));
	assign we_a = in_acc && ld_ok && (op == mmc_pkg::OP_LOAD_A);
	assign we_b = in_acc && ld_ok && (op == mmc_pkg::OP_LOAD_B);
	assign we_d = in_acc && ld_ok && (op == mmc_pkg::OP_LOAD_D);

	assign last_k = ({1'b0, k_q} + 4'd1 == klim);
	assign last_j = ({1'b0, j_q} + 4'd1 == ncols);
	assign last_i = ({1'b0, i_q} + 4'd1 == ra);

	// Operand addresses: A or mid row i column k, B or D row k column j.
	assign ra_a = AW'(i_q * 6'(MAX_DIM) + 6'(k_q));
	assign ra_m = ra_a;
	assign ra_b = AW'(k_q * 6'(MAX_DIM) + 6'(j_q));
	assign wa_m = AW'(oi_s2 * 6'(MAX_DIM) + 6'(oj_s2));
	assign we_m = fin_s3 && !pass_s2;

	mmc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_a (
		.clk(clk), .we(we_a), .waddr(ld_addr), .wdata(elem_value),
		.raddr(ra_a), .rdata(rd_a));
	mmc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_b (
		.clk(clk), .we(we_b), .waddr(ld_addr), .wdata(elem_value),
		.raddr(ra_b), .rdata(rd_b));
	mmc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_d (
		.clk(clk), .we(we_d), .waddr(ld_addr), .wdata(elem_value),
		.raddr(ra_b), .rdata(rd_d));
	mmc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_m (
		.clk(clk), .we(we_m), .waddr(wa_m), .wdata(narrow),
		.raddr(ra_m), .rdata(rd_m));

	mmc_mac u_mac (
		.clk(clk), .arst_n(arst_n), .vld_s2(vld_s1), .first_s2(first_s1),
		.opa_s2(opa_s2), .opb_s2(opb_s2), .acc_q(acc_q), .narrow(narrow));

	always_comb begin
		opa_s2 = (pass_s1 && cfg_q.chain_enable) ? rd_m : rd_a;
		opb_s2 = (pass_s1 && cfg_q.chain_enable) ? rd_d : rd_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rows_a: 4'd8, inner_dim: 4'd8, cols_b: 4'd8,
				chain_enable: 1'b0, cols_d: 4'd8};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mmc_pkg::REG_ROWS_A: cfg_q.rows_a <= cfg_data;
				mmc_pkg::REG_INNER_DIM: cfg_q.inner_dim <= cfg_data;
				mmc_pkg::REG_COLS_B: cfg_q.cols_b <= cfg_data;
				mmc_pkg::REG_CHAIN_ENABLE: cfg_q.chain_enable <= cfg_data[0];
				mmc_pkg::REG_COLS_D: cfg_q.cols_d <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fin_s1 <= 1'b0;
			fin_s2 <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			fin_s1 <= (state_q == ST_RUN) && last_k;
			fin_s2 <= fin_s1;
			fin_s3 <= fin_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == 3'd0);
		pass_s1 <= pass_q;
		pass_s2 <= pass_s1;
		oi_s1 <= i_q;
		oj_s1 <= j_q;
		oi_s2 <= oi_s1;
		oj_s2 <= oj_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			drain_q <= '0;
			out_valid <= 1'b0;
			out_row <= '0;
			out_col <= '0;
			out_value <= '0;
			last <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && op == mmc_pkg::OP_COMPUTE) begin
						state_q <= ST_RUN;
						pass_q <= !cfg_q.chain_enable;
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
					end
				end
				ST_RUN: begin
					if (last_k) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd3) begin
						if (pass_q) begin
							state_q <= ST_OUT;
							out_valid <= 1'b1;
							out_row <= i_q;
							out_col <= j_q;
							out_value <= acc_q;
							last <= last_i && last_j;
						end else begin
							state_q <= ST_RUN;
							k_q <= '0;
							if (last_j) begin
								j_q <= '0;
								if (last_i) begin
									i_q <= '0;
									pass_q <= 1'b1;
								end else begin
									i_q <= i_q + 3'd1;
								end
							end else begin
								j_q <= j_q + 3'd1;
							end
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						k_q <= '0;
						if (last) begin
							state_q <= ST_IDLE;
							i_q <= '0;
							j_q <= '0;
						end else begin
							state_q <= ST_RUN;
							if (last_j) begin
								j_q <= '0;
								i_q <= i_q + 3'd1;
							end else begin
								j_q <= j_q + 3'd1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ bench/testbench.sv @@
// Testbench of the matrix multiply chain: random loads and computes against a scoreboard.
`timescale 1ns / 100ps

module testbench;

	class mmc_scoreboard;
		typedef struct {
			logic [2:0] r;
			logic [2:0] c;
			logic [34:0] v;
			logic l;
		} elem_res_t;

		elem_res_t pending[$];
		logic signed [15:0] mat_a[64];
		logic signed [15:0] mat_b[64];
		logic signed [15:0] mat_d[64];
		logic signed [15:0] mat_mid[64];
		mmc_pkg::cfg_t cfg;
		int errors;
		int checked;

		function new();
			cfg.rows_a = 8;
			cfg.inner_dim = 8;
			cfg.cols_b = 8;
			cfg.chain_enable = 0;
			cfg.cols_d = 8;
			errors = 0;
			checked = 0;
		endfunction

		static function int dim_of(logic [3:0] v);
			if (v == 0) return 1;
			if (v > mmc_pkg::MAX_DIM_DEF) return mmc_pkg::MAX_DIM_DEF;
			return int'(v);
		endfunction

		function void write_reg(logic [2:0] idx, logic [3:0] d);
			case (idx)
				mmc_pkg::REG_ROWS_A: cfg.rows_a = d;
				mmc_pkg::REG_INNER_DIM: cfg.inner_dim = d;
				mmc_pkg::REG_COLS_B: cfg.cols_b = d;
				mmc_pkg::REG_CHAIN_ENABLE: cfg.chain_enable = d[0];
				mmc_pkg::REG_COLS_D: cfg.cols_d = d;
				default: ;
			endcase
		endfunction

		function void note_input(logic [1:0] op, logic [2:0] row, logic [2:0] col,
				logic signed [15:0] val);
			int ra, kd, cb, cd, nc, i, j, k;
			longint s, q;
			elem_res_t e;
			if (op != mmc_pkg::OP_COMPUTE) begin
				case (op)
					mmc_pkg::OP_LOAD_A: mat_a[row * 8 + col] = val;
					mmc_pkg::OP_LOAD_B: mat_b[row * 8 + col] = val;
					default: mat_d[row * 8 + col] = val;
				endcase
				return;
			end
			ra = dim_of(cfg.rows_a);
			kd = dim_of(cfg.inner_dim);
			cb = dim_of(cfg.cols_b);
			cd = dim_of(cfg.cols_d);
			if (cfg.chain_enable) begin
				for (i = 0; i < ra; i++) begin
					for (j = 0; j < cb; j++) begin
						s = 0;
						for (k = 0; k < kd; k++)
							s += longint'(mat_a[i * 8 + k]) * longint'(mat_b[k * 8 + j]);
						q = s >>> 12;
						if (q > 32767) q = 32767;
						if (q < -32768) q = -32768;
						mat_mid[i * 8 + j] = q[15:0];
					end
				end
			end
			nc = cfg.chain_enable ? cd : cb;
			for (i = 0; i < ra; i++) begin
				for (j = 0; j < nc; j++) begin
					s = 0;
					if (cfg.chain_enable) begin
						for (k = 0; k < cb; k++)
							s += longint'(mat_mid[i * 8 + k]) * longint'(mat_d[k * 8 + j]);
					end else begin
						for (k = 0; k < kd; k++)
							s += longint'(mat_a[i * 8 + k]) * longint'(mat_b[k * 8 + j]);
					end
					e.r = 3'(i);
					e.c = 3'(j);
					e.v = s[34:0];
					e.l = (i + 1 == ra) && (j + 1 == nc);
					pending.push_back(e);
				end
			end
		endfunction

		function void check_result(logic [2:0] r, logic [2:0] c, logic [34:0] v, logic l);
			elem_res_t e;
			if (pending.size() == 0) begin
				$error("result transfer with no expected element: row %0d col %0d", r, c);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (r !== e.r) begin
				$error("out_row expected %0d actual %0d", e.r, r);
				errors++;
			end
			if (c !== e.c) begin
				$error("out_col expected %0d actual %0d", e.c, c);
				errors++;
			end
			if (v !== e.v) begin
				$error("out_value expected %0d actual %0d", $signed(e.v), $signed(v));
				errors++;
			end
			if (l !== e.l) begin
				$error("last expected %0d actual %0d", e.l, l);
				errors++;
			end
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 900000;

	logic clk = 0;
	logic arst_n = 0;
	logic valid = 0;
	logic stall;
	logic [1:0] op = mmc_pkg::OP_LOAD_A;
	logic [2:0] row = 0;
	logic [2:0] col = 0;
	logic signed [15:0] elem_value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic signed [34:0] out_value;
	logic last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [3:0] cfg_data = 0;

	mmc_scoreboard sb = new();
	bit loaded_a[64];
	bit loaded_b[64];
	bit loaded_d[64];
	int burst_left = 0;
	int items_sent = 0;
	int computes = 0;
	int settings = 0;
	int cycles = 0;
	int rx_mode = 0;

	matrix_multiply_chain dut (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .stall(stall), .op(op), .row(row), .col(col),
		.elem_value(elem_value),
		.out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
		.out_col(out_col), .out_value(out_value), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_row, out_col, out_value, last);
		if (cycles % 173 == 0)
			rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			default: out_stall <= ((cycles % 16) < 11);
		endcase
	end

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(logic [1:0] o, logic [2:0] r, logic [2:0] c,
			logic signed [15:0] v);
		valid <= 1;
		op <= o;
		row <= r;
		col <= c;
		elem_value <= v;
		@(posedge clk);
		while (stall) @(posedge clk);
		sb.note_input(o, r, c, v);
		items_sent++;
		case (o)
			mmc_pkg::OP_LOAD_A: loaded_a[r * 8 + c] = 1;
			mmc_pkg::OP_LOAD_B: loaded_b[r * 8 + c] = 1;
			mmc_pkg::OP_LOAD_D: loaded_d[r * 8 + c] = 1;
			default: computes++;
		endcase
		if (burst_left == 0) begin
			valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic wait_idle();
		valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [3:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [3:0] ra, logic [3:0] kd, logic [3:0] cb, logic ch,
			logic [3:0] cd);
		wait_idle();
		write_reg(mmc_pkg::REG_ROWS_A, ra);
		write_reg(mmc_pkg::REG_INNER_DIM, kd);
		write_reg(mmc_pkg::REG_COLS_B, cb);
		write_reg(mmc_pkg::REG_CHAIN_ENABLE, {3'b0, ch});
		write_reg(mmc_pkg::REG_COLS_D, cd);
		settings++;
	endtask

	// Loads every entry that the next compute reads and that was never written.
	task automatic fill_needed();
		int ra, kd, cb, cd, i, j;
		ra = mmc_scoreboard::dim_of(sb.cfg.rows_a);
		kd = mmc_scoreboard::dim_of(sb.cfg.inner_dim);
		cb = mmc_scoreboard::dim_of(sb.cfg.cols_b);
		cd = mmc_scoreboard::dim_of(sb.cfg.cols_d);
		for (i = 0; i < ra; i++)
			for (j = 0; j < kd; j++)
				if (!loaded_a[i * 8 + j])
					send_item(mmc_pkg::OP_LOAD_A, 3'(i), 3'(j), rand_elem());
		for (i = 0; i < kd; i++)
			for (j = 0; j < cb; j++)
				if (!loaded_b[i * 8 + j])
					send_item(mmc_pkg::OP_LOAD_B, 3'(i), 3'(j), rand_elem());
		if (sb.cfg.chain_enable)
			for (i = 0; i < cb; i++)
				for (j = 0; j < cd; j++)
					if (!loaded_d[i * 8 + j])
						send_item(mmc_pkg::OP_LOAD_D, 3'(i), 3'(j), rand_elem());
	endtask

	task automatic random_phase(int n);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				fill_needed();
				send_item(mmc_pkg::OP_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
			end else begin
				send_item(2'($urandom_range(0, 2)), 3'($urandom), 3'($urandom),
					rand_elem());
			end
		end
		fill_needed();
		send_item(mmc_pkg::OP_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
	endtask

	initial begin
		int p;
		logic [3:0] dims[4];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		set_config(1, 1, 1, 0, 1);
		send_item(mmc_pkg::OP_LOAD_A, 0, 0, 16'sh8000);
		send_item(mmc_pkg::OP_LOAD_B, 0, 0, 16'sh8000);
		send_item(mmc_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'sh7fff);
		send_item(mmc_pkg::OP_LOAD_A, 0, 0, 16'sh7fff);
		send_item(mmc_pkg::OP_LOAD_D, 7, 7, 16'sh8000);
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);

		set_config(1, 2, 1, 1, 2);
		send_item(mmc_pkg::OP_LOAD_A, 0, 0, 16'sh8000);
		send_item(mmc_pkg::OP_LOAD_A, 0, 1, 16'sh8000);
		send_item(mmc_pkg::OP_LOAD_B, 0, 0, 16'sh8000);
		send_item(mmc_pkg::OP_LOAD_B, 1, 0, 16'sh8000);
		send_item(mmc_pkg::OP_LOAD_D, 0, 0, 16'sh7fff);
		send_item(mmc_pkg::OP_LOAD_D, 0, 1, 16'sh8000);
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);
		send_item(mmc_pkg::OP_LOAD_B, 0, 0, 16'sh7fff);
		send_item(mmc_pkg::OP_LOAD_B, 1, 0, 16'sh7fff);
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);
		send_item(mmc_pkg::OP_LOAD_A, 0, 0, -16'sd1);
		send_item(mmc_pkg::OP_LOAD_B, 0, 0, 16'sd1);
		send_item(mmc_pkg::OP_LOAD_B, 1, 0, 16'sd0);
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);

		set_config(0, 0, 0, 1, 0);
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);

		set_config(1, 15, 1, 1, 15);
		fill_needed();
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);
		set_config(15, 1, 15, 0, 1);
		fill_needed();
		send_item(mmc_pkg::OP_COMPUTE, 0, 0, 0);

		dims = '{0, 1, 2, 3};
		for (p = 0; p < 8; p++) begin
			if (p == 4) set_config(8, 3, 1, 0, 2);
			else set_config(dims[$urandom_range(0, 3)], dims[$urandom_range(0, 3)],
				dims[$urandom_range(0, 3)], 1'($urandom_range(0, 1)),
				dims[$urandom_range(0, 3)]);
			random_phase($urandom_range(2, 6));
		end

		wait_idle();
		$display("Sent %0d input items with %0d computes over %0d register settings.",
			items_sent, computes, settings);
		$display("Checked %0d result elements in %0d cycles.", sb.checked, cycles);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

@@ sim.f @@
src/mmc_pkg.sv
src/mmc_mem.sv
src/mmc_mac.sv
src/matrix_multiply_chain.sv
bench/testbench.sv
